[rtl/bit_stream_buffer_defines.svh]
// assertion macros for the bit stream buffer
`ifndef BIT_STREAM_BUFFER_DEFINES_SVH
`define BIT_STREAM_BUFFER_DEFINES_SVH
`ifndef SYNTH
`define BSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSB_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/bsb_pkg.sv]
// types and constants of the bit stream buffer
package bsb_pkg;

  localparam int STORE_WORDS = 1024;
  localparam int WORD_W      = 64;
  localparam int SHIFT_W     = $clog2(WORD_W);
  localparam int CNT_W       = SHIFT_W + 1;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int PTR_W       = $clog2(STORE_WORDS + 1);
  localparam int POS_W       = 17;
  localparam int IDX_W       = 10;
  localparam int KIND_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE_BIT  = 3'd0,
    KIND_READ_BIT   = 3'd1,
    KIND_FLUSH      = 3'd2,
    KIND_READ_SEEK  = 3'd3,
    KIND_WRITE_SEEK = 3'd4,
    KIND_REWIND     = 3'd5,
    KIND_LOAD_WORD  = 3'd6,
    KIND_READ_WORD  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bit_in;
    logic [POS_W-1:0]  seek_offset;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_data;
  } in_t;

  typedef struct packed {
    logic              bit_out;
    logic [WORD_W-1:0] word_out;
    logic [POS_W-1:0]  read_position;
    logic [POS_W-1:0]  write_position;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

[rtl/bsb_store.sv]
// word store with one write port, one registered read port and write bypass
module bsb_store (
  input  logic                           clk_i,
  input  bsb_pkg::wr_req_t               wr_i,
  input  bsb_pkg::rd_req_t               rd_i,
  output logic [bsb_pkg::WORD_W-1:0]     rdata_o
);

  logic [bsb_pkg::WORD_W-1:0] mem [bsb_pkg::STORE_WORDS];
  logic [bsb_pkg::WORD_W-1:0] rdata_q;
  logic [bsb_pkg::WORD_W-1:0] fwd_data_q;
  logic                       fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // a write landing on the same edge as the read is taken from the bypass
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q    <= mem[rd_i.addr];
      fwd_hit_q  <= wr_i.we && (wr_i.addr == rd_i.addr);
      fwd_data_q <= wr_i.data;
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : rdata_q;

endmodule

[rtl/bit_stream_buffer.sv]
// top level of the bit stream buffer
// Bit-granular packer and unpacker over a store of 64-bit words, least significant
// bit first. One beat is accepted every cycle while the output is not stalled; its
// result passes the input and result registers. The store read for a beat is issued
// at the edge that takes it in, and the whole state update (partial word, bit count,
// word pointer) is combinational between the two registers. The store has one write
// port and one registered read port; a word written by one beat and read by the next
// comes through a bypass. The store is not cleared after reset, so a word must be
// written before it is read; the block is ready as soon as reset drops.
`include "bit_stream_buffer_defines.svh"

module bit_stream_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsb_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bsb_pkg::out_t out_o
);

  bsb_pkg::in_t  a_q;
  logic          a_valid_q;
  logic          a_fire;
  logic          in_acc;
  bsb_pkg::out_t out_q;
  logic          out_valid_q;
  bsb_pkg::out_t res;

  logic [bsb_pkg::WORD_W-1:0] pw_q, pw_d, pw_tmp, src;
  logic [bsb_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_tmp;
  logic [bsb_pkg::PTR_W-1:0]  ptr_q, ptr_d;
  logic [bsb_pkg::WORD_W-1:0] rdata;
  logic [bsb_pkg::POS_W-bsb_pkg::SHIFT_W-1:0] a_w, in_w;
  logic [bsb_pkg::SHIFT_W-1:0] a_rem;
  logic                        a_w_in, a_w_end, a_idx_in;

  bsb_pkg::wr_req_t wr;
  bsb_pkg::rd_req_t rd;

  assign a_fire     = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign a_w      = a_q.seek_offset[bsb_pkg::POS_W-1:bsb_pkg::SHIFT_W];
  assign a_rem    = a_q.seek_offset[bsb_pkg::SHIFT_W-1:0];
  assign in_w     = in_i.seek_offset[bsb_pkg::POS_W-1:bsb_pkg::SHIFT_W];
  assign a_w_in   = 32'(a_w) < bsb_pkg::STORE_WORDS;
  assign a_w_end  = 32'(a_w) <= bsb_pkg::STORE_WORDS;
  assign a_idx_in = 32'(a_q.word_index) < bsb_pkg::STORE_WORDS;

  always_comb begin
    pw_d    = pw_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    pw_tmp  = pw_q;
    cnt_tmp = cnt_q;
    src     = pw_q;
    wr      = '0;
    res     = '0;
    if (a_fire) begin
      case (a_q.kind)
        bsb_pkg::KIND_WRITE_BIT: begin
          if (!cnt_q[bsb_pkg::CNT_W-1] && a_q.bit_in) begin
            pw_tmp[cnt_q[bsb_pkg::SHIFT_W-1:0]] = 1'b1;
          end
          cnt_tmp = cnt_q + 1'b1;
          if (cnt_tmp[bsb_pkg::CNT_W-1]) begin
            if (32'(ptr_q) < bsb_pkg::STORE_WORDS) begin
              wr.we   = 1'b1;
              wr.addr = ptr_q[bsb_pkg::ADDR_W-1:0];
              wr.data = pw_tmp;
              ptr_d   = ptr_q + 1'b1;
            end else begin
              res.overflow = 1'b1;
            end
            pw_d  = '0;
            cnt_d = '0;
          end else begin
            pw_d  = pw_tmp;
            cnt_d = cnt_tmp;
          end
        end
        bsb_pkg::KIND_READ_BIT: begin
          if (cnt_q == '0 && !(32'(ptr_q) < bsb_pkg::STORE_WORDS)) begin
            res.overflow = 1'b1;
          end else begin
            if (cnt_q == '0) begin
              src     = rdata;
              ptr_d   = ptr_q + 1'b1;
              cnt_tmp = bsb_pkg::CNT_W'(bsb_pkg::WORD_W);
            end
            cnt_d       = cnt_tmp - 1'b1;
            res.bit_out = src[0];
            pw_d        = src >> 1;
          end
        end
        bsb_pkg::KIND_FLUSH: begin
          if (cnt_q != '0) begin
            if (32'(ptr_q) < bsb_pkg::STORE_WORDS) begin
              wr.we   = 1'b1;
              wr.addr = ptr_q[bsb_pkg::ADDR_W-1:0];
              wr.data = pw_q;
              ptr_d   = ptr_q + 1'b1;
            end else begin
              res.overflow = 1'b1;
            end
            pw_d  = '0;
            cnt_d = '0;
          end
        end
        bsb_pkg::KIND_READ_SEEK, bsb_pkg::KIND_WRITE_SEEK: begin
          if (a_rem != '0) begin
            if (a_w_in) begin
              if (a_q.kind == bsb_pkg::KIND_READ_SEEK) begin
                pw_d  = rdata >> a_rem;
                ptr_d = bsb_pkg::PTR_W'(a_w) + 1'b1;
                cnt_d = bsb_pkg::CNT_W'(bsb_pkg::WORD_W) - bsb_pkg::CNT_W'(a_rem);
              end else begin
                pw_d  = rdata & ((bsb_pkg::WORD_W'(1) << a_rem) - 1'b1);
                ptr_d = bsb_pkg::PTR_W'(a_w);
                cnt_d = bsb_pkg::CNT_W'(a_rem);
              end
            end else begin
              res.overflow = 1'b1;
            end
          end else if (a_w_end) begin
            ptr_d = bsb_pkg::PTR_W'(a_w);
            pw_d  = '0;
            cnt_d = '0;
          end else begin
            res.overflow = 1'b1;
          end
        end
        bsb_pkg::KIND_REWIND: begin
          ptr_d = '0;
          pw_d  = '0;
          cnt_d = '0;
        end
        bsb_pkg::KIND_LOAD_WORD: begin
          if (a_idx_in) begin
            wr.we   = 1'b1;
            wr.addr = bsb_pkg::ADDR_W'(a_q.word_index);
            wr.data = a_q.word_data;
          end else begin
            res.overflow = 1'b1;
          end
        end
        bsb_pkg::KIND_READ_WORD: begin
          if (a_idx_in) begin
            res.word_out = rdata;
          end else begin
            res.overflow = 1'b1;
          end
        end
        default: begin
          res.overflow = 1'b0;
        end
      endcase
    end
    res.read_position  = (bsb_pkg::POS_W'(ptr_d) << bsb_pkg::SHIFT_W)
                         - bsb_pkg::POS_W'(cnt_d);
    res.write_position = (bsb_pkg::POS_W'(ptr_d) << bsb_pkg::SHIFT_W)
                         + bsb_pkg::POS_W'(cnt_d);
  end

  // read address for the beat being taken in, against the state it will see
  always_comb begin
    rd.re   = 1'b0;
    rd.addr = bsb_pkg::ADDR_W'(in_i.word_index);
    if (in_acc) begin
      case (in_i.kind)
        bsb_pkg::KIND_READ_BIT: begin
          rd.re   = 1'b1;
          rd.addr = ptr_d[bsb_pkg::ADDR_W-1:0];
        end
        bsb_pkg::KIND_READ_SEEK, bsb_pkg::KIND_WRITE_SEEK: begin
          rd.re   = 1'b1;
          rd.addr = bsb_pkg::ADDR_W'(in_w);
        end
        bsb_pkg::KIND_READ_WORD: begin
          rd.re   = 1'b1;
        end
        default: begin
          rd.re   = 1'b0;
        end
      endcase
    end
  end

  bsb_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pw_q        <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
    end else begin
      pw_q  <= pw_d;
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= in_i;
    end
    if (a_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BSB_ASSERT(a_cnt_range, clk_i, rst_ni, !cnt_q[bsb_pkg::CNT_W-1], "bit count reached a full word")
  `BSB_ASSERT(a_ptr_range, clk_i, rst_ni, 32'(ptr_q) <= bsb_pkg::STORE_WORDS, "word pointer past store end")
  `BSB_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !a_fire, $stable(ptr_q) && $stable(cnt_q) && $stable(pw_q), "state moved without a beat")
  `BSB_ASSERT(a_stall_cause, clk_i, rst_ni, !in_stall_o || (out_valid_q && out_stall_i), "input stalled with room downstream")

endmodule

[tb/sv/testbench.sv]
// testbench for the bit stream buffer: random and directed beats checked against a predictor
`timescale 1ns / 100ps

module testbench;
  import bsb_pkg::*;

  localparam int ITEMS      = 500;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;

  class stream_scoreboard;
    logic [WORD_W-1:0] store_copy [STORE_WORDS];
    bit                written [STORE_WORDS];
    logic [WORD_W-1:0] gathered;
    int unsigned       fill;
    int unsigned       ptr;
    out_t              due_results [$];
    int unsigned       mismatches;

    function new();
      gathered   = '0;
      fill       = 0;
      ptr        = 0;
      mismatches = 0;
    endfunction

    // store address a beat would read, or -1
    function int fetch_address(in_t b);
      int unsigned w;
      int unsigned rem;
      w   = b.seek_offset >> 6;
      rem = b.seek_offset[5:0];
      case (b.kind)
        KIND_READ_BIT: if (fill == 0 && ptr < STORE_WORDS) return ptr;
        KIND_READ_SEEK, KIND_WRITE_SEEK: if (rem != 0 && w < STORE_WORDS) return w;
        KIND_READ_WORD: if (b.word_index < STORE_WORDS) return b.word_index;
        default: ;
      endcase
      return -1;
    endfunction

    function bit store_partial();
      bit ovf;
      ovf = 1'b0;
      if (ptr < STORE_WORDS) begin
        store_copy[ptr] = gathered;
        written[ptr]    = 1'b1;
        ptr++;
      end else begin
        ovf = 1'b1;
      end
      gathered = '0;
      fill     = 0;
      return ovf;
    endfunction

    function void predict_beat(in_t b);
      out_t        r;
      int unsigned w;
      int unsigned rem;
      logic [31:0] pos;
      r   = '0;
      w   = b.seek_offset >> 6;
      rem = b.seek_offset[5:0];
      case (b.kind)
        KIND_WRITE_BIT: begin
          if (b.bit_in) gathered[fill] = 1'b1;
          fill++;
          if (fill >= WORD_W) r.overflow = store_partial();
        end
        KIND_READ_BIT: begin
          if (fill == 0 && ptr >= STORE_WORDS) begin
            r.overflow = 1'b1;
          end else begin
            if (fill == 0) begin
              gathered = store_copy[ptr];
              ptr++;
              fill = WORD_W;
            end
            fill--;
            r.bit_out = gathered[0];
            gathered  = gathered >> 1;
          end
        end
        KIND_FLUSH: if (fill != 0) r.overflow = store_partial();
        KIND_READ_SEEK, KIND_WRITE_SEEK: begin
          if (rem != 0) begin
            if (w < STORE_WORDS) begin
              if (b.kind == KIND_READ_SEEK) begin
                gathered = store_copy[w] >> rem;
                ptr      = w + 1;
                fill     = WORD_W - rem;
              end else begin
                gathered = store_copy[w] & ((64'd1 << rem) - 64'd1);
                ptr      = w;
                fill     = rem;
              end
            end else begin
              r.overflow = 1'b1;
            end
          end else if (w <= STORE_WORDS) begin
            ptr      = w;
            gathered = '0;
            fill     = 0;
          end else begin
            r.overflow = 1'b1;
          end
        end
        KIND_REWIND: begin
          ptr      = 0;
          gathered = '0;
          fill     = 0;
        end
        KIND_LOAD_WORD: begin
          if (b.word_index < STORE_WORDS) begin
            store_copy[b.word_index] = b.word_data;
            written[b.word_index]    = 1'b1;
          end else begin
            r.overflow = 1'b1;
          end
        end
        default: begin
          if (b.word_index < STORE_WORDS) r.word_out = store_copy[b.word_index];
          else r.overflow = 1'b1;
        end
      endcase
      pos = ptr * WORD_W - fill;
      r.read_position = pos[POS_W-1:0];
      pos = ptr * WORD_W + fill;
      r.write_position = pos[POS_W-1:0];
      due_results = {due_results, r};
    endfunction

    function void check_beat(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bit %0b word %h rpos %0d wpos %0d ovf %0b",
                   got.bit_out, got.word_out, got.read_position, got.write_position,
                   got.overflow);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch (expected/actual): bit %0b/%0b word %h/%h ",
                      "rpos %0d/%0d wpos %0d/%0d ovf %0b/%0b"},
                     want.bit_out, got.bit_out, want.word_out, got.word_out,
                     want.read_position, got.read_position,
                     want.write_position, got.write_position,
                     want.overflow, got.overflow);
        end
      end
    endfunction
  endclass

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  in_t   in_i        = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_o;

  stream_scoreboard sb = new();
  int sent        = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;
  bit hold_done   = 1'b0;

  bit_stream_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_t pick(kind_e k);
    in_t b;
    b.kind        = k;
    b.bit_in      = 1'($urandom);
    b.seek_offset = POS_W'($urandom);
    b.word_index  = IDX_W'($urandom);
    b.word_data   = {$urandom, $urandom};
    return b;
  endfunction

  function automatic in_t beat(kind_e k, logic bit_v, logic [POS_W-1:0] off,
                               logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    in_t b;
    b.kind        = k;
    b.bit_in      = bit_v;
    b.seek_offset = off;
    b.word_index  = idx;
    b.word_data   = data;
    return b;
  endfunction

  function automatic logic [POS_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return POS_W'($urandom_range(0, 64 * 16));
    if (r < 85) return POS_W'($urandom_range(65400, 65700));
    return POS_W'($urandom_range(0, 17'h1ffff));
  endfunction

  task automatic drive(in_t b);
    int addr;
    int gap;
    bit stalled;
    addr = sb.fetch_address(b);
    // never read a store word that was never written: load it instead
    if (addr >= 0 && !sb.written[addr]) begin
      b.kind       = KIND_LOAD_WORD;
      b.word_index = addr[IDX_W-1:0];
      b.word_data  = {$urandom, $urandom};
    end
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= b;
    // stall is settled by the falling edge and holds until the next rising edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    sb.predict_beat(b);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
  endtask

  task automatic random_phase();
    int r;
    int n;
    in_t b;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      if ($urandom_range(0, 1)) begin
        b = pick(KIND_WRITE_SEEK);
        b.seek_offset = POS_W'($urandom_range(0, 64 * 12));
        drive(b);
      end else begin
        drive(pick(KIND_REWIND));
      end
      n = $urandom_range(1, 90);
      repeat (n) drive(pick(KIND_WRITE_BIT));
      if ($urandom_range(0, 1)) drive(pick(KIND_FLUSH));
    end else if (r < 50) begin
      if ($urandom_range(0, 1)) begin
        b = pick(KIND_READ_SEEK);
        b.seek_offset = POS_W'($urandom_range(0, 64 * 12));
        drive(b);
      end else begin
        drive(pick(KIND_REWIND));
      end
      n = $urandom_range(1, 80);
      repeat (n) drive(pick(KIND_READ_BIT));
    end else if (r < 65) begin
      n = $urandom_range(1, 6);
      repeat (n) drive(pick($urandom_range(0, 1) ? KIND_LOAD_WORD : KIND_READ_WORD));
    end else if (r < 75) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        b = pick($urandom_range(0, 1) ? KIND_READ_SEEK : KIND_WRITE_SEEK);
        b.seek_offset = pick_offset();
        drive(b);
      end
    end else if (r < 85) begin
      // accesses at the store end
      b = pick($urandom_range(0, 1) ? KIND_READ_SEEK : KIND_WRITE_SEEK);
      b.seek_offset = POS_W'(STORE_WORDS * WORD_W);
      drive(b);
      n = $urandom_range(0, 1) ? WORD_W : $urandom_range(1, 10);
      repeat (n) drive(pick($urandom_range(0, 3) != 0 ? KIND_WRITE_BIT : KIND_READ_BIT));
      drive(pick(KIND_FLUSH));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) drive(pick(kind_e'($urandom_range(0, 7))));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    drive(beat(KIND_WRITE_BIT,  1'b1, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_WRITE_BIT,  1'b0, 17'h1ffff,  10'h3ff,  '1));
    drive(beat(KIND_WRITE_BIT,  1'b1, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_FLUSH,      1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_FLUSH,      1'b1, 17'h1ffff,  10'h3ff,  '1));
    drive(beat(KIND_REWIND,     1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_READ_BIT,   1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_READ_BIT,   1'b1, 17'h1ffff,  10'h3ff,  '1));
    drive(beat(KIND_LOAD_WORD,  1'b0, 17'd0,      10'd1023, '1));
    drive(beat(KIND_LOAD_WORD,  1'b0, 17'd0,      10'd512,  64'd0));
    drive(beat(KIND_READ_WORD,  1'b0, 17'd0,      10'd1023, 64'd0));
    drive(beat(KIND_READ_WORD,  1'b0, 17'd0,      10'd512,  64'd0));
    drive(beat(KIND_READ_SEEK,  1'b0, 17'd65535,  10'd0,    64'd0));
    drive(beat(KIND_READ_BIT,   1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_READ_BIT,   1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_WRITE_SEEK, 1'b0, 17'd65536,  10'd0,    64'd0));
    drive(beat(KIND_WRITE_BIT,  1'b1, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_FLUSH,      1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_WRITE_SEEK, 1'b0, 17'd65535,  10'd0,    64'd0));
    drive(beat(KIND_WRITE_BIT,  1'b0, 17'd0,      10'd0,    64'd0));
    drive(beat(KIND_READ_SEEK,  1'b0, 17'h1ffff,  10'd0,    64'd0));
    drive(beat(KIND_WRITE_SEEK, 1'b0, 17'd65537,  10'd0,    64'd0));
    drive(beat(KIND_READ_SEEK,  1'b0, 17'd65600,  10'd0,    64'd0));
    drive(beat(KIND_READ_WORD,  1'b0, 17'd0,      10'd1023, 64'd0));
    drive(beat(KIND_WRITE_SEEK, 1'b0, 17'd0,      10'd0,    64'd0));
    drain();

    while (sent < ITEMS) begin
      steady = ($urandom_range(0, 99) < 30);
      random_phase();
      if ($urandom_range(0, 99) < 4) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sent >= 200) begin
        // long hold-off so the block fills and stalls its input
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 50) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end else if (n < 90) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(8, 30)) @(posedge clk_i);
        end
      end
    end
  end

  // handshakes are settled by the falling edge and taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(out_o);
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bsb_pkg.sv
rtl/bsb_store.sv
rtl/bit_stream_buffer.sv
tb/sv/testbench.sv
